@@ rtl/core/dft_magnitude_spectrum_top_assert.svh @@
// assertion macros for the dft magnitude spectrum block
`ifndef DFT_MAGNITUDE_SPECTRUM_TOP_ASSERT_SVH
`define DFT_MAGNITUDE_SPECTRUM_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define DMS_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("dft magnitude spectrum assertion failed");
`define DMS_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("dft magnitude spectrum assertion failed");
`else
`define DMS_ASSERT_NOW(label, clk, rst, pre, post)
`define DMS_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

@@ rtl/core/dms_pkg.sv @@
// constants, widths and twiddle table of the dft magnitude spectrum block
`timescale 1ns / 1ps
`default_nettype none
package dms_pkg;

   localparam int Points   = 64;
   localparam int IdxW     = $clog2(Points);
   localparam int SampleW  = 16;
   localparam int TwW      = 16;
   localparam int ProdW    = SampleW + TwW;
   localparam int AccW     = ProdW + IdxW;
   localparam int ShiftA   = 6;
   localparam int AbsW     = AccW - ShiftA;
   localparam int SqW      = 2 * AbsW;
   localparam int SumW     = SqW + 1;
   localparam int RootTop  = ((SumW - 1) / 2) * 2;
   localparam int MagDiv   = 512 * Points;
   localparam int BinW     = 6;
   localparam int MagW     = 16;
   localparam int RspDataW = ((BinW + MagW + 7) / 8) * 8;

   localparam logic [63:0] HalfPiQ30 = 64'd1686629713;
   localparam logic [63:0] OneQ30    = 64'd1073741824;

   // entry m: cosine in the upper half, sine in the lower half, both q1.15
   typedef logic [Points-1:0][2*TwW-1:0] twiddle_rom_type;

   function automatic logic [TwW-1:0] q30_to_q15(input logic signed [63:0] v);
      logic signed [63:0] t;
      t = (v + 64'sd16384) >>> 15;
      if (t > 64'sd32767) begin
         return 16'h7FFF;
      end else if (t < -64'sd32768) begin
         return 16'h8000;
      end
      return t[TwW-1:0];
   endfunction

   // taylor sums to the seventeenth power in q2.30, then quadrant folding
   function automatic logic [2*TwW-1:0] twiddle_entry(input int unsigned m);
      logic [63:0]        m4;
      logic [63:0]        q;
      logic [63:0]        rem;
      logic [63:0]        r;
      logic [63:0]        r2;
      logic [63:0]        ts;
      logic [63:0]        tc;
      logic signed [63:0] s;
      logic signed [63:0] c;
      logic signed [63:0] cc;
      logic signed [63:0] ss;
      int                 n;
      m4  = 64'(4 * m);
      q   = (m4 / 64'(Points)) & 64'd3;
      rem = m4 % 64'(Points);
      r   = (HalfPiQ30 * rem) / 64'(Points);
      r2  = (r * r) >> 30;
      ts  = r;
      tc  = OneQ30;
      s   = $signed(r);
      c   = $signed(OneQ30);
      for (n = 1; n <= 8; n++) begin
         ts = (ts * r2) >> 30;
         tc = (tc * r2) >> 30;
         case (n)
            1: begin
               ts = ts / 64'd6;
               tc = tc / 64'd2;
            end
            2: begin
               ts = ts / 64'd20;
               tc = tc / 64'd12;
            end
            3: begin
               ts = ts / 64'd42;
               tc = tc / 64'd30;
            end
            4: begin
               ts = ts / 64'd72;
               tc = tc / 64'd56;
            end
            5: begin
               ts = ts / 64'd110;
               tc = tc / 64'd90;
            end
            6: begin
               ts = ts / 64'd156;
               tc = tc / 64'd132;
            end
            7: begin
               ts = ts / 64'd210;
               tc = tc / 64'd182;
            end
            default: begin
               ts = ts / 64'd272;
               tc = tc / 64'd240;
            end
         endcase
         if ((n & 1) != 0) begin
            s = s - $signed(ts);
            c = c - $signed(tc);
         end else begin
            s = s + $signed(ts);
            c = c + $signed(tc);
         end
      end
      case (q[1:0])
         2'd0: begin
            cc = c;
            ss = s;
         end
         2'd1: begin
            cc = -s;
            ss = c;
         end
         2'd2: begin
            cc = -c;
            ss = -s;
         end
         default: begin
            cc = s;
            ss = -c;
         end
      endcase
      return {q30_to_q15(cc), q30_to_q15(ss)};
   endfunction

   function automatic twiddle_rom_type build_twiddle_rom();
      twiddle_rom_type rom;
      int unsigned     m;
      for (m = 0; m < Points; m++) begin
         rom[m] = twiddle_entry(m);
      end
      return rom;
   endfunction

   localparam twiddle_rom_type TwiddleRom = build_twiddle_rom();

endpackage
`default_nettype wire

@@ rtl/core/dft_magnitude_spectrum_top.sv @@
// dft magnitude spectrum block: frame buffer, shared mac pair and magnitude unit
//
// Input channel req_: one signed 16-bit sample per word. After 64 samples the
// frame is complete; req_tready drops while the spectrum is being computed and
// rises again once the last bin has read its final sample from the frame memory.
// Output channel rsp_: one word per bin, bins 0..63 in ascending order, with
// rsp_tlast on the final bin. Each word carries floor(|X[k]|) / 64 as a
// floored integer.
// Each bin runs 64 multiply-accumulates through the frame memory read port and
// the twiddle rom; the pipeline then drains and hands the sums over. The
// magnitude unit (squares, then a 33-step integer square root at one step a
// cycle) works on bin k while bin k+1 accumulates.
// Reset (synchronous, active high) empties the frame and all pipelines; the
// frame memory itself is not cleared and needs no clearing pass.
// A stalled receiver holds the result in the output register; the magnitude
// unit then waits, and the next bin does not start until its sums are taken,
// so no result is lost. Samples of the next frame are taken once the last
// bin has read its final sample, even while its results still wait.
`timescale 1ns / 1ps
`default_nettype none
`include "dft_magnitude_spectrum_top_assert.svh"
module dft_magnitude_spectrum_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [15:0]                   req_tdata,   // [15:0] sample
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [dms_pkg::RspDataW-1:0]  rsp_tdata,   // [5:0] bin_index, [21:6] magnitude
   output logic                          rsp_tlast    // last_bin
);

   typedef enum logic [1:0] {
      CTL_FILL = 2'b01,
      CTL_RUN  = 2'b10
   } ctl_state_type;

   typedef enum logic [4:0] {
      MAG_IDLE = 5'b00001,
      MAG_SQ   = 5'b00010,
      MAG_SUM  = 5'b00100,
      MAG_ROOT = 5'b01000,
      MAG_OUT  = 5'b10000
   } mag_state_type;

   // frame memory
   logic [dms_pkg::SampleW-1:0] frame_mem [dms_pkg::Points];

   // sequencer
   ctl_state_type               ctl_state_ff, ctl_state_in;
   logic [dms_pkg::IdxW-1:0]    fill_ff, fill_in;
   logic [dms_pkg::IdxW-1:0]    k_ff, k_in;
   logic [dms_pkg::IdxW-1:0]    i_ff, i_in;
   logic [dms_pkg::IdxW-1:0]    m_ff, m_in;
   logic                        bin_active_ff, bin_active_in;
   logic [dms_pkg::IdxW:0]      m_sum;
   logic [dms_pkg::IdxW:0]      m_wrap;
   logic                        req_accept;
   logic                        issue_last;

   // mac pipeline
   logic                             p1_valid_ff, p1_first_ff, p1_last_ff;
   logic                             p2_valid_ff, p2_first_ff, p2_last_ff;
   logic signed [dms_pkg::SampleW-1:0] x_ff;
   logic signed [dms_pkg::TwW-1:0]     cos_ff;
   logic signed [dms_pkg::TwW-1:0]     sin_ff;
   logic signed [dms_pkg::ProdW-1:0]   prod_re_ff;
   logic signed [dms_pkg::ProdW-1:0]   prod_im_ff;
   logic signed [dms_pkg::AccW-1:0]    acc_re_ff;
   logic signed [dms_pkg::AccW-1:0]    acc_im_ff;
   logic signed [dms_pkg::AccW-1:0]    acc_re_base;
   logic signed [dms_pkg::AccW-1:0]    acc_im_base;
   logic                               done_valid_ff, done_valid_in;

   // magnitude unit
   mag_state_type               mag_state_ff, mag_state_in;
   logic [dms_pkg::AccW-1:0]    abs_re;
   logic [dms_pkg::AccW-1:0]    abs_im;
   logic [dms_pkg::AbsW-1:0]    a_ff;
   logic [dms_pkg::AbsW-1:0]    b_ff;
   logic [dms_pkg::SqW-1:0]     asq_ff;
   logic [dms_pkg::SqW-1:0]     bsq_ff;
   logic [dms_pkg::SumW-1:0]    v_ff;
   logic [dms_pkg::SumW-1:0]    res_ff;
   logic [dms_pkg::SumW-1:0]    bit_ff;
   logic [dms_pkg::SumW-1:0]    trial;
   logic                        take;
   logic [dms_pkg::SumW-1:0]    quot;
   logic [dms_pkg::MagW-1:0]    mag_sat;
   logic [dms_pkg::IdxW-1:0]    out_bin_ff, out_bin_in;
   logic                        out_load;

   // output register
   logic                          rsp_tvalid_ff, rsp_tvalid_in;
   logic [dms_pkg::RspDataW-1:0]  rsp_data_ff;
   logic                          rsp_last_ff;

   assign req_tready = (ctl_state_ff == CTL_FILL);
   assign req_accept = req_tvalid && req_tready;
   assign issue_last = bin_active_ff && (i_ff == dms_pkg::IdxW'(dms_pkg::Points - 1));

   // twiddle index steps by k and wraps at the frame length
   assign m_sum  = {1'b0, m_ff} + {1'b0, k_ff};
   assign m_wrap = (m_sum >= (dms_pkg::IdxW + 1)'(dms_pkg::Points))
                 ? m_sum - (dms_pkg::IdxW + 1)'(dms_pkg::Points) : m_sum;

   always_comb begin
      ctl_state_in  = ctl_state_ff;
      fill_in       = fill_ff;
      k_in          = k_ff;
      i_in          = i_ff;
      m_in          = m_ff;
      bin_active_in = bin_active_ff;
      unique case (ctl_state_ff)
         CTL_FILL: begin
            if (req_accept) begin
               if (fill_ff == dms_pkg::IdxW'(dms_pkg::Points - 1)) begin
                  fill_in      = '0;
                  k_in         = '0;
                  ctl_state_in = CTL_RUN;
               end else begin
                  fill_in = fill_ff + 1'b1;
               end
            end
         end
         CTL_RUN: begin
            if (bin_active_ff) begin
               i_in = i_ff + 1'b1;
               m_in = m_wrap[dms_pkg::IdxW-1:0];
               if (issue_last) begin
                  bin_active_in = 1'b0;
                  if (k_ff == dms_pkg::IdxW'(dms_pkg::Points - 1)) begin
                     ctl_state_in = CTL_FILL;
                  end else begin
                     k_in = k_ff + 1'b1;
                  end
               end
            end else if (!done_valid_ff && !p1_valid_ff && !p2_valid_ff) begin
               // next bin starts only once the previous sums have been taken
               bin_active_in = 1'b1;
               i_in          = '0;
               m_in          = '0;
            end
         end
         default: begin
            ctl_state_in = CTL_FILL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_state_ff  <= CTL_FILL;
         fill_ff       <= '0;
         k_ff          <= '0;
         bin_active_ff <= 1'b0;
      end else begin
         ctl_state_ff  <= ctl_state_in;
         fill_ff       <= fill_in;
         k_ff          <= k_in;
         bin_active_ff <= bin_active_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in;
      m_ff <= m_in;
   end

   // frame memory: written while filling, read one word a cycle while a bin runs
   always_ff @(posedge clock) begin
      if (req_accept) begin
         frame_mem[fill_ff] <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (bin_active_ff) begin
         x_ff <= $signed(frame_mem[i_ff]);
      end
   end

   always_ff @(posedge clock) begin
      cos_ff     <= $signed(dms_pkg::TwiddleRom[m_ff][2*dms_pkg::TwW-1:dms_pkg::TwW]);
      sin_ff     <= $signed(dms_pkg::TwiddleRom[m_ff][dms_pkg::TwW-1:0]);
      p1_first_ff <= (i_ff == '0);
      p1_last_ff  <= issue_last;
      prod_re_ff  <= x_ff * cos_ff;
      prod_im_ff  <= x_ff * sin_ff;
      p2_first_ff <= p1_first_ff;
      p2_last_ff  <= p1_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= bin_active_ff;
         p2_valid_ff <= p1_valid_ff;
      end
   end

   assign acc_re_base = p2_first_ff ? '0 : acc_re_ff;
   assign acc_im_base = p2_first_ff ? '0 : acc_im_ff;

   // the accumulators double as the hand-over register to the magnitude unit
   always_ff @(posedge clock) begin
      if (p2_valid_ff) begin
         acc_re_ff <= acc_re_base + dms_pkg::AccW'(prod_re_ff);
         acc_im_ff <= acc_im_base + dms_pkg::AccW'(prod_im_ff);
      end
   end

   always_comb begin
      done_valid_in = done_valid_ff;
      priority if (p2_valid_ff && p2_last_ff) begin
         done_valid_in = 1'b1;
      end else if ((mag_state_ff == MAG_IDLE) && done_valid_ff) begin
         done_valid_in = 1'b0;
      end
   end

   // magnitude unit
   assign abs_re  = acc_re_ff[dms_pkg::AccW-1] ? $unsigned(-acc_re_ff) : $unsigned(acc_re_ff);
   assign abs_im  = acc_im_ff[dms_pkg::AccW-1] ? $unsigned(-acc_im_ff) : $unsigned(acc_im_ff);
   assign trial   = res_ff + bit_ff;
   assign take    = (v_ff >= trial);
   assign quot    = res_ff / dms_pkg::MagDiv;
   assign mag_sat = ((quot >> dms_pkg::MagW) != '0) ? '1 : quot[dms_pkg::MagW-1:0];
   assign out_load = (mag_state_ff == MAG_OUT) && (!rsp_tvalid_ff || rsp_tready);

   always_comb begin
      mag_state_in  = mag_state_ff;
      out_bin_in    = out_bin_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
      unique case (mag_state_ff)
         MAG_IDLE: begin
            if (done_valid_ff) begin
               mag_state_in = MAG_SQ;
            end
         end
         MAG_SQ: begin
            mag_state_in = MAG_SUM;
         end
         MAG_SUM: begin
            mag_state_in = MAG_ROOT;
         end
         MAG_ROOT: begin
            // the step with the lowest trial bit is the last one
            if (bit_ff[0]) begin
               mag_state_in = MAG_OUT;
            end
         end
         MAG_OUT: begin
            if (out_load) begin
               rsp_tvalid_in = 1'b1;
               mag_state_in  = MAG_IDLE;
               if (out_bin_ff == dms_pkg::IdxW'(dms_pkg::Points - 1)) begin
                  out_bin_in = '0;
               end else begin
                  out_bin_in = out_bin_ff + 1'b1;
               end
            end
         end
         default: begin
            mag_state_in = MAG_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_valid_ff <= 1'b0;
         mag_state_ff  <= MAG_IDLE;
         out_bin_ff    <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         done_valid_ff <= done_valid_in;
         mag_state_ff  <= mag_state_in;
         out_bin_ff    <= out_bin_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      unique case (mag_state_ff)
         MAG_IDLE: begin
            a_ff <= abs_re[dms_pkg::AccW-1:dms_pkg::ShiftA];
            b_ff <= abs_im[dms_pkg::AccW-1:dms_pkg::ShiftA];
         end
         MAG_SQ: begin
            asq_ff <= a_ff * a_ff;
            bsq_ff <= b_ff * b_ff;
         end
         MAG_SUM: begin
            v_ff   <= {1'b0, asq_ff} + {1'b0, bsq_ff};
            res_ff <= '0;
            bit_ff <= dms_pkg::SumW'(1) << dms_pkg::RootTop;
         end
         MAG_ROOT: begin
            if (take) begin
               v_ff   <= v_ff - trial;
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         MAG_OUT: begin
            if (out_load) begin
               rsp_data_ff <= dms_pkg::RspDataW'({mag_sat, dms_pkg::BinW'(out_bin_ff)});
               rsp_last_ff <= (out_bin_ff == dms_pkg::IdxW'(dms_pkg::Points - 1));
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // a finished bin never lands on sums that are still waiting
   `DMS_ASSERT_NOW(a_no_overwrite, clock, reset, p2_valid_ff && p2_last_ff, !done_valid_ff)
   // samples are never written while the memory is being read for a bin
   `DMS_ASSERT_NOW(a_fill_excludes_run, clock, reset, req_tvalid && req_tready, !bin_active_ff)
   // a stalled receiver keeps the magnitude unit waiting on its result
   `DMS_ASSERT_NEXT(a_out_holds, clock, reset,
      (mag_state_ff == MAG_OUT) && rsp_tvalid && !rsp_tready, mag_state_ff == MAG_OUT)

endmodule
`default_nettype wire

@@ tb/dft_magnitude_spectrum_checker.sv @@
// checker that predicts the magnitude spectrum of each frame and compares the result words
`timescale 1ns / 1ps
module dft_magnitude_spectrum_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   input  logic                         req_tready,
   input  logic [15:0]                  req_tdata,   // [15:0] sample
   input  logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   input  logic [dms_pkg::RspDataW-1:0] rsp_tdata,   // [5:0] bin_index, [21:6] magnitude
   input  logic                         rsp_tlast,   // last_bin
   output int                           mismatch_count,
   output int                           bins_pending
);

   localparam int FrameLen = dms_pkg::Points;

   typedef struct {
      logic [5:0]  bin_index;
      logic [15:0] magnitude;
      logic        last_bin;
   } bin_result_type;

   logic signed [15:0] cos_q15 [FrameLen];
   logic signed [15:0] sin_q15 [FrameLen];
   logic signed [15:0] frame_samples [FrameLen];
   int                 fill_count;
   bin_result_type     expected_bins [$];

   function automatic logic signed [15:0] round_q30_to_q15(input longint v);
      longint t;
      t = (v + 64'sd16384) >>> 15;
      if (t > 32767) begin
         t = 32767;
      end else if (t < -32768) begin
         t = -32768;
      end
      return t[15:0];
   endfunction

   // twiddle table: taylor series in q2.30 over one quadrant, then folded
   initial begin : build_twiddles
      logic [63:0] m4;
      logic [63:0] r;
      logic [63:0] r2;
      logic [63:0] ts;
      logic [63:0] tc;
      longint      s;
      longint      c;
      longint      cc;
      longint      ss;
      int          quadrant;
      int          m;
      int          n;
      for (m = 0; m < FrameLen; m++) begin
         m4       = 64'(4 * m);
         quadrant = int'((m4 / 64'(FrameLen)) % 64'd4);
         r        = (64'd1686629713 * (m4 % 64'(FrameLen))) / 64'(FrameLen);
         r2       = (r * r) >> 30;
         ts       = r;
         tc       = 64'd1 << 30;
         s        = longint'(r);
         c        = longint'(tc);
         for (n = 1; n <= 8; n++) begin
            ts = ((ts * r2) >> 30) / 64'((2 * n) * (2 * n + 1));
            tc = ((tc * r2) >> 30) / 64'((2 * n - 1) * (2 * n));
            if (n % 2 == 1) begin
               s = s - longint'(ts);
               c = c - longint'(tc);
            end else begin
               s = s + longint'(ts);
               c = c + longint'(tc);
            end
         end
         case (quadrant)
            0: begin
               cc = c;
               ss = s;
            end
            1: begin
               cc = -s;
               ss = c;
            end
            2: begin
               cc = -c;
               ss = -s;
            end
            default: begin
               cc = s;
               ss = -c;
            end
         endcase
         cos_q15[m] = round_q30_to_q15(cc);
         sin_q15[m] = round_q30_to_q15(ss);
      end
   end

   task automatic predict_spectrum();
      longint         re;
      longint         im;
      longint         x;
      logic [63:0]    a;
      logic [63:0]    b;
      logic [63:0]    power;
      logic [63:0]    root;
      logic [63:0]    trial;
      logic [63:0]    mag;
      int             k;
      int             i;
      int             m;
      int             bit_pos;
      bin_result_type bin_word;
      for (k = 0; k < FrameLen; k++) begin
         re = 0;
         im = 0;
         for (i = 0; i < FrameLen; i++) begin
            m  = (i * k) % FrameLen;
            x  = longint'(frame_samples[i]);
            re = re + x * longint'(cos_q15[m]);
            im = im + x * longint'(sin_q15[m]);
         end
         a     = (re < 0) ? -re : re;
         b     = (im < 0) ? -im : im;
         a     = a >> 6;
         b     = b >> 6;
         power = a * a + b * b;
         // floored square root, one bit at a time from the top
         root = 64'd0;
         for (bit_pos = 31; bit_pos >= 0; bit_pos--) begin
            trial = root | (64'd1 << bit_pos);
            if (trial * trial <= power) begin
               root = trial;
            end
         end
         mag = root / 64'(512 * FrameLen);
         if (mag > 64'd65535) begin
            mag = 64'd65535;
         end
         bin_word.bin_index = k[5:0];
         bin_word.magnitude = mag[15:0];
         bin_word.last_bin  = (k == FrameLen - 1);
         expected_bins.push_back(bin_word);
      end
   endtask

   always @(posedge clock) begin : monitor
      bin_result_type want;
      if (reset) begin
         fill_count     = 0;
         mismatch_count = 0;
         bins_pending   = 0;
         expected_bins.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            frame_samples[fill_count] = req_tdata;
            fill_count++;
            if (fill_count == FrameLen) begin
               fill_count = 0;
               predict_spectrum();
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_bins.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("unexpected bin word: bin %0d magnitude %0d last %0b",
                           rsp_tdata[5:0], rsp_tdata[21:6], rsp_tlast);
               end
            end else begin
               want = expected_bins.pop_front();
               if (rsp_tdata[5:0] !== want.bin_index || rsp_tdata[21:6] !== want.magnitude ||
                   rsp_tlast !== want.last_bin) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display({"bin word mismatch: expected bin %0d magnitude %0d last %0b,",
                               " got bin %0d magnitude %0d last %0b"},
                              want.bin_index, want.magnitude, want.last_bin,
                              rsp_tdata[5:0], rsp_tdata[21:6], rsp_tlast);
                  end
               end
            end
         end
         bins_pending = expected_bins.size();
      end
   end

endmodule

@@ tb/dft_magnitude_spectrum_top_tb.sv @@
// testbench top for the dft magnitude spectrum block: clock, reset, sample frames and verdict
`timescale 1ns / 1ps
module dft_magnitude_spectrum_top_tb;

   localparam int FrameLen  = dms_pkg::Points;
   localparam int NumFrames = 7;

   typedef enum int {
      PatUniform,
      PatSmall,
      PatConstant,
      PatAlternate,
      PatSquare
   } frame_pattern_type;

   logic                         clock;
   logic                         reset;
   logic                         req_tvalid;
   logic                         req_tready;
   logic [15:0]                  req_tdata;   // [15:0] sample
   logic                         rsp_tvalid;
   logic                         rsp_tready;
   logic [dms_pkg::RspDataW-1:0] rsp_tdata;   // [5:0] bin_index, [21:6] magnitude
   logic                         rsp_tlast;   // last_bin
   int                           mismatch_count;
   int                           bins_pending;
   bit                           sender_idles;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   dft_magnitude_spectrum_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   dft_magnitude_spectrum_checker spectrum_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .bins_pending   (bins_pending)
   );

   // called at a rising edge, returns at the edge where the word is taken
   task automatic send_sample(input logic [15:0] value);
      int gap;
      gap = sender_idles ? $urandom_range(0, 18) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
   endtask

   initial begin : bin_receiver
      int stall;
      bit receiver_idles;
      receiver_idles = 1'b1;
      rsp_tready <= 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 31) == 0) begin
            receiver_idles = !receiver_idles;
         end
         stall = receiver_idles ? $urandom_range(0, 18) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(negedge clock);
         while (!rsp_tvalid) @(negedge clock);
         @(posedge clock);
      end
   end

   initial begin : stimulus
      logic [15:0]       directed [25];
      logic [15:0]       level;
      logic [15:0]       value;
      frame_pattern_type pattern;
      int                half_period;
      int                frame;
      int                i;
      directed = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001,
                   16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h5555,
                   16'hAAAA, 16'h00FF, 16'hFF00, 16'h0F0F, 16'hF0F0,
                   16'h4000, 16'hC000, 16'h0001, 16'hFFFE, 16'h7FFE,
                   16'h8001, 16'h3333, 16'hCCCC, 16'h0002, 16'h8000};
      reset        <= 1'b1;
      req_tvalid   <= 1'b0;
      req_tdata    <= 16'h0000;
      sender_idles = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < 25; i++) begin
         send_sample(directed[i]);
      end
      // rest of the first frame is random
      for (i = 25; i < FrameLen; i++) begin
         send_sample(16'($urandom_range(0, 65535)));
      end

      for (frame = 1; frame < NumFrames; frame++) begin
         pattern      = frame_pattern_type'($urandom_range(0, 5) % 5);
         half_period  = $urandom_range(1, 32);
         level        = ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
         sender_idles = ($urandom_range(0, 3) != 0);
         for (i = 0; i < FrameLen; i++) begin
            case (pattern)
               PatSmall: begin
                  value = 16'($urandom_range(0, 511) - 256);
               end
               PatConstant: begin
                  value = level;
               end
               PatAlternate: begin
                  value = i[0] ? ~level : level;
               end
               PatSquare: begin
                  value = (((i / half_period) % 2) != 0) ? ~level : level;
               end
               default: begin
                  value = 16'($urandom_range(0, 65535));
               end
            endcase
            send_sample(value);
         end
      end
      req_tvalid <= 1'b0;

      @(negedge clock);
      while (bins_pending != 0) @(negedge clock);
      repeat (300) @(posedge clock);
      if (mismatch_count == 0 && bins_pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
